@@ hdl/ptp_pkg.sv @@
// shared constants, codes and types of the periodic timer pool
package ptp_pkg;

  localparam int unsigned TIMER_COUNT = 8;
  localparam int unsigned MS_PER_TICK = 10;
  localparam int unsigned MAX_RESULTS = 8;

  localparam int unsigned CMD_W    = 2;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned ID_W     = 3;
  localparam int unsigned TICK_W   = 13;
  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  localparam int unsigned IDX_W  = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int unsigned FIRE_W = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;

  // ms to ticks by reciprocal multiply, exact for every 16 bit period
  localparam int unsigned TICK_SHIFT = MS_W + $clog2(MS_PER_TICK);
  localparam longint unsigned RECIP =
      ((64'd1 << TICK_SHIFT) + MS_PER_TICK - 1) / MS_PER_TICK;
  localparam int unsigned RECIP_W = MS_W + 2;
  localparam int unsigned PROD_W  = MS_W + RECIP_W + $clog2(MS_PER_TICK);

  typedef enum logic [CMD_W-1:0] {
    CMD_REGISTER = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_SERVICE  = 2'd2,
    CMD_UNUSED   = 2'd3
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_REGISTERED = 3'd0,
    STATUS_FULL       = 3'd1,
    STATUS_TICKED     = 3'd2,
    STATUS_FIRED      = 3'd3,
    STATUS_NONE       = 3'd4
  } status_e;

  typedef struct packed {
    cmd_e              cmd;
    logic              start;
    logic              go;
    logic              kill;
    logic [TICK_W-1:0] ticks;
  } cell_ctl_t;

endpackage

@@ hdl/ptp_cell.sv @@
// one timer slot of the chain, acting while it holds the scan token
module ptp_cell import ptp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cell_ctl_t ctl_i,
  input  logic      token_i,
  output logic      token_o,
  output logic      hit_o
);

  logic              running_q, running_d;
  logic [TICK_W-1:0] rem_q, rem_d;
  logic [TICK_W-1:0] per_q, per_d;
  logic              token_q, token_d;
  logic              cond;

  always_comb begin
    unique case (ctl_i.cmd)
      CMD_REGISTER: cond = !running_q;
      CMD_SERVICE:  cond = running_q && (rem_q == '0);
      default:      cond = 1'b0;
    endcase
  end

  assign hit_o   = token_q && cond;
  assign token_o = token_q;

  always_comb begin
    running_d = running_q;
    rem_d     = rem_q;
    per_d     = per_q;
    if (token_q && ctl_i.go) begin
      unique case (ctl_i.cmd)
        CMD_REGISTER: begin
          if (cond) begin
            running_d = 1'b1;
            per_d     = ctl_i.ticks;
            rem_d     = ctl_i.ticks;
          end
        end
        CMD_TICK: begin
          if (rem_q != '0) rem_d = rem_q - TICK_W'(1);
        end
        CMD_SERVICE: begin
          if (cond) rem_d = per_q;
        end
        default: ;
      endcase
    end
  end

  // token moves one cell per step, cleared whenever the scan ends
  always_comb begin
    token_d = token_q;
    if (ctl_i.kill) token_d = 1'b0;
    else if (ctl_i.start || ctl_i.go) token_d = token_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q <= 1'b0;
      rem_q     <= '0;
      per_q     <= '0;
      token_q   <= 1'b0;
    end else begin
      running_q <= running_d;
      rem_q     <= rem_d;
      per_q     <= per_d;
      token_q   <= token_d;
    end
  end

endmodule

@@ hdl/ptp_ctrl.sv @@
// request sequencer: period conversion, scan stepping and result register
module ptp_ctrl import ptp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [MS_W-1:0]     period_ms_i,
  input  logic                hit_i,
  output cell_ctl_t           ctl_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     timer_id_o,
  output logic                last_o
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SCAN   = 3'b010,
    ST_FINISH = 3'b100
  } state_e;

  localparam logic [IDX_W-1:0]  IDX_LAST  = IDX_W'(TIMER_COUNT - 1);
  localparam logic [FIRE_W-1:0] FIRE_LAST = FIRE_W'(MAX_RESULTS - 1);

  state_e            state_q, state_d;
  cmd_e              cmd_q, cmd_d;
  logic [TICK_W-1:0] ticks_q, ticks_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [FIRE_W-1:0] fired_q, fired_d;
  status_e           fin_status_q, fin_status_d;
  logic [ID_W-1:0]   fin_id_q, fin_id_d;

  logic              out_valid_q;
  status_e           status_q;
  logic [ID_W-1:0]   id_q;
  logic              last_q;

  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     quot;
  logic [TICK_W-1:0]     ticks_sat;
  logic [ID_W+IDX_W-1:0] idx_ext;
  logic [ID_W-1:0]       idx_id;
  logic                  out_free, accept, last_cell;
  logic                  go, start, kill, done;
  logic                  emit, emit_last;
  status_e               emit_status;
  logic [ID_W-1:0]       emit_id;

  assign prod      = PROD_W'(period_ms_i) * PROD_W'(RECIP);
  assign quot      = prod >> TICK_SHIFT;
  assign ticks_sat = (quot > PROD_W'(TICK_MAX)) ? TICK_MAX : quot[TICK_W-1:0];

  assign idx_ext   = {{ID_W{1'b0}}, idx_q};
  assign idx_id    = idx_ext[ID_W-1:0];
  assign out_free  = !out_valid_q || !out_stall_i;
  assign accept    = in_valid_i && (state_q == ST_IDLE);
  assign last_cell = (idx_q == IDX_LAST);

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    ticks_d      = ticks_q;
    idx_d        = idx_q;
    fired_d      = fired_q;
    fin_status_d = fin_status_q;
    fin_id_d     = fin_id_q;
    go           = 1'b0;
    start        = 1'b0;
    kill         = 1'b0;
    done         = 1'b0;
    emit         = 1'b0;
    emit_status  = fin_status_q;
    emit_id      = fin_id_q;
    emit_last    = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          cmd_d    = cmd_e'(command_i);
          ticks_d  = ticks_sat;
          idx_d    = '0;
          fired_d  = '0;
          fin_id_d = '0;
          unique case (cmd_e'(command_i))
            CMD_REGISTER: fin_status_d = STATUS_FULL;
            CMD_TICK:     fin_status_d = STATUS_TICKED;
            default:      fin_status_d = STATUS_NONE;
          endcase
          if (cmd_e'(command_i) != CMD_UNUSED) begin
            start   = 1'b1;
            state_d = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        unique case (cmd_q)
          CMD_REGISTER: begin
            go = 1'b1;
            if (hit_i) begin
              fin_status_d = STATUS_REGISTERED;
              fin_id_d     = idx_id;
              done         = 1'b1;
            end else if (last_cell) begin
              done = 1'b1;
            end
          end
          CMD_TICK: begin
            go   = 1'b1;
            done = last_cell;
          end
          CMD_SERVICE: begin
            // a held fired slot goes out once the next one is found
            if (hit_i && (fin_status_q == STATUS_FIRED)) begin
              emit      = 1'b1;
              emit_last = 1'b0;
              go        = out_free;
            end else begin
              go = 1'b1;
            end
            if (go && hit_i) begin
              fin_status_d = STATUS_FIRED;
              fin_id_d     = idx_id;
              fired_d      = fired_q + FIRE_W'(1);
              if (fired_q == FIRE_LAST) done = 1'b1;
            end
            if (go && last_cell) done = 1'b1;
          end
          default: begin
            go   = 1'b1;
            done = 1'b1;
          end
        endcase
        if (go) idx_d = idx_q + IDX_W'(1);
        if (done) begin
          kill    = 1'b1;
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        emit = 1'b1;
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q        <= cmd_d;
    ticks_q      <= ticks_d;
    idx_q        <= idx_d;
    fired_q      <= fired_d;
    fin_status_q <= fin_status_d;
    fin_id_q     <= fin_id_d;
    if (emit && out_free) begin
      status_q <= emit_status;
      id_q     <= emit_id;
      last_q   <= emit_last;
    end
  end

  assign ctl_o.cmd   = cmd_q;
  assign ctl_o.start = start;
  assign ctl_o.go    = go;
  assign ctl_o.kill  = kill;
  assign ctl_o.ticks = ticks_q;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign timer_id_o  = id_q;
  assign last_o      = last_q;

endmodule

@@ hdl/periodic_timer_pool.sv @@
// Pool of periodic countdown timers, one chain cell per slot, driven by
// register, tick and service requests. A scan token walks the chain one
// cell per cycle, but a service scan waits while the output side stalls
// the report of a fired slot. A tick request visits every slot, a register
// request stops at the first idle slot and a service request reports the
// fired slots that it finds on its way; a new request is taken the
// cycle after the last result enters the output register. The period is
// converted to ticks with a reciprocal multiply when the request is taken.
// Result order and fields follow the slot index; timer_id is the slot index
// truncated to three bits.
module periodic_timer_pool import ptp_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [CMD_W-1:0]    command_i,
  input  logic [MS_W-1:0]     period_ms_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [STATUS_W-1:0] status_o,
  output logic [ID_W-1:0]     timer_id_o,
  output logic                last_o
);

  cell_ctl_t              ctl;
  logic [TIMER_COUNT:0]   token;
  logic [TIMER_COUNT-1:0] hits;
  logic                   hit_any;

  assign token[0] = ctl.start;

  for (genvar i = 0; i < TIMER_COUNT; i++) begin : g_cell
    ptp_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl),
      .token_i (token[i]),
      .token_o (token[i+1]),
      .hit_o   (hits[i])
    );
  end

  // token is one-hot, so an or picks the hit of the active cell
  assign hit_any = |hits;

  ptp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .period_ms_i (period_ms_i),
    .hit_i       (hit_any),
    .ctl_o       (ctl),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .timer_id_o  (timer_id_o),
    .last_o      (last_o)
  );

`ifndef SYNTH
  a_token_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(token[TIMER_COUNT:1]))
    else $error("more than one cell holds the scan token");

  a_idle_no_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_stall_o |-> (token[TIMER_COUNT:1] == '0))
    else $error("scan token left in the chain while idle");

  a_single_result_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == STATUS_REGISTERED || status_o == STATUS_FULL ||
                    status_o == STATUS_TICKED || status_o == STATUS_NONE)
    |-> last_o)
    else $error("single result of a request not marked last");
`endif

endmodule
